// ===== design/seven_segment_decimal_scan_macros.svh =====
// ----------------------------------------------------------------------------
// Seven-segment decimal scan: assertion macros
// Shared concurrent-assertion wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_DECIMAL_SCAN_MACROS_SVH
`define SEVEN_SEGMENT_DECIMAL_SCAN_MACROS_SVH

// Checked only out of reset.
`define SSDS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SSDS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/ssds_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment decimal scan package
// Command codes, queue entry type and the segment decode table.
// ----------------------------------------------------------------------------
package ssds_pkg;

    localparam int BCD_DIGITS = 5;          // a 16-bit value has at most five

    localparam logic [1:0] CMD_LEFT  = 2'd0;
    localparam logic [1:0] CMD_RIGHT = 2'd1;
    localparam logic [1:0] CMD_ALL   = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [15:0] FOUR_DIGIT_MAX = 16'd9999;

    // floor(x / 10) == (x * 0xCCCD) >> 19 for every 16-bit x
    localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_CONVERT
    } t_front_state;

    typedef struct packed {
        logic [1:0]                  mode;
        logic [BCD_DIGITS-1:0][3:0]  digits;   // index 0 is the ones digit
    } t_queue_entry;

    function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
        logic [6:0] pattern;
        case (digit)
            4'd0:    pattern = 7'h3F;
            4'd1:    pattern = 7'h06;
            4'd2:    pattern = 7'h5B;
            4'd3:    pattern = 7'h4F;
            4'd4:    pattern = 7'h66;
            4'd5:    pattern = 7'h6D;
            4'd6:    pattern = 7'h7D;
            4'd7:    pattern = 7'h07;
            4'd8:    pattern = 7'h7F;
            4'd9:    pattern = 7'h6F;
            default: pattern = 7'h00;
        endcase
        return pattern;
    endfunction

endpackage

// ===== design/ssds_front.sv =====
// ----------------------------------------------------------------------------
// Seven-segment decimal scan: front end
// Accepts requests, saturates four-digit modes, drops the unused command and
// splits values into digits, one divide-by-ten step per cycle unless held.
// ----------------------------------------------------------------------------
module ssds_front import ssds_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [15:0]  i_value,
    input  logic [1:0]   i_command,
    output logic         o_push_valid,
    input  logic         i_push_ready,
    output t_queue_entry o_push_entry
);

    localparam logic [2:0] LAST_STEP = 3'(BCD_DIGITS - 1);

    t_front_state              r_state, n_state;
    logic [15:0]               r_rem;
    logic [1:0]                r_mode;
    logic [2:0]                r_step;
    logic [BCD_DIGITS-2:0][3:0] r_digits;

    logic        w_last_step;
    logic        w_advance;
    logic        w_accept;
    logic        w_keep;
    logic [31:0] w_product;
    logic [12:0] w_quot;
    logic [15:0] w_ten_quot;
    logic [15:0] w_diff;
    logic [3:0]  w_digit;
    logic [15:0] w_sat_value;

    // Divide the remainder by ten through the reciprocal
    always_comb begin
        w_product  = r_rem * RECIP_TEN;
        w_quot     = w_product[31:RECIP_SHIFT];
        w_ten_quot = {w_quot, 3'b000} + {2'b00, w_quot, 1'b0};
        w_diff     = r_rem - w_ten_quot;
        w_digit    = w_diff[3:0];
    end

    always_comb begin
        if (i_command != CMD_ALL && i_value > FOUR_DIGIT_MAX) begin
            w_sat_value = FOUR_DIGIT_MAX;
        end else begin
            w_sat_value = i_value;
        end
    end

    // Outputs
    always_comb begin
        w_last_step  = (r_step == LAST_STEP);
        o_push_valid = (r_state == FRONT_CONVERT) && w_last_step;
        w_advance    = (r_state == FRONT_CONVERT) && (!w_last_step || i_push_ready);
        o_in_ready   = (r_state == FRONT_IDLE) || (w_last_step && i_push_ready);
        w_accept     = i_in_valid && o_in_ready;
        w_keep       = w_accept && (i_command != CMD_NONE);
        o_push_entry.mode   = r_mode;
        o_push_entry.digits = {w_digit, r_digits};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FRONT_IDLE: begin
                if (w_keep) begin
                    n_state = FRONT_CONVERT;
                end
            end
            FRONT_CONVERT: begin
                if (w_last_step && i_push_ready) begin
                    n_state = w_keep ? FRONT_CONVERT : FRONT_IDLE;
                end
            end
            default: n_state = FRONT_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FRONT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rem  <= w_sat_value;
            r_mode <= i_command;
            r_step <= 3'd0;
        end else if (w_advance) begin
            r_rem    <= {3'b000, w_quot};
            r_digits <= {w_digit, r_digits[BCD_DIGITS-2:1]};
            r_step   <= r_step + 3'd1;
        end
    end

endmodule

// ===== design/ssds_queue.sv =====
// ----------------------------------------------------------------------------
// Seven-segment decimal scan: decode queue
// Two-entry FIFO between the digit converter and the scanner.
// ----------------------------------------------------------------------------
module ssds_queue import ssds_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  t_queue_entry i_push_entry,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output t_queue_entry o_pop_entry
);

    t_queue_entry r_mem [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;

    logic w_push;
    logic w_pop;

    always_comb begin
        o_push_ready = (r_count != 2'd2);
        o_pop_valid  = (r_count != 2'd0);
        o_pop_entry  = r_mem[r_rd_ptr];
        w_push       = i_push_valid && o_push_ready;
        w_pop        = o_pop_valid && i_pop_ready;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/ssds_back.sv =====
// ----------------------------------------------------------------------------
// Seven-segment decimal scan: scanner
// Walks the digit positions of one queued value, blanks leading zeros and
// drives one registered digit result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module ssds_back import ssds_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_pop_valid,
    output logic         o_pop_ready,
    input  t_queue_entry i_pop_entry,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [7:0]   o_digit_enable_n,
    output logic [7:0]   o_segments_n,
    output logic         o_last_digit
);

    t_queue_entry r_entry;
    logic         r_active;
    logic [2:0]   r_idx;
    logic         r_leading;
    logic         r_out_valid;
    logic [7:0]   r_digit_enable_n;
    logic [7:0]   r_segments_n;
    logic         r_last_digit;

    logic [7:0][3:0] w_dig8;
    logic [2:0]      w_last_idx;
    logic [2:0]      w_sel;
    logic [2:0]      w_bit;
    logic [3:0]      w_digit;
    logic            w_last;
    logic            w_blank;
    logic            w_emit;
    logic            w_load;

    always_comb begin
        w_dig8     = {12'h000, r_entry.digits};
        w_last_idx = (r_entry.mode == CMD_ALL) ? 3'd7 : 3'd3;
        w_sel      = w_last_idx - r_idx;
        w_digit    = w_dig8[w_sel];
        w_last     = (r_idx == w_last_idx);
        w_blank    = r_leading && (w_digit == 4'd0) && !w_last;
        // position p drives bit 8 - p; right mode starts at position 5
        w_bit      = (r_entry.mode == CMD_RIGHT) ? (3'd3 - r_idx) : (3'd7 - r_idx);
        w_emit     = r_active && (!r_out_valid || i_out_ready);
        w_load     = i_pop_valid && (!r_active || (w_emit && w_last));
        o_pop_ready = !r_active || (w_emit && w_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_active <= 1'b1;
            end else if (w_emit && w_last) begin
                r_active <= 1'b0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_entry   <= i_pop_entry;
            r_idx     <= 3'd0;
            r_leading <= 1'b1;
        end else if (w_emit) begin
            r_idx     <= r_idx + 3'd1;
            r_leading <= w_blank;
        end
        if (w_emit) begin
            r_digit_enable_n <= ~(8'h01 << w_bit);
            r_segments_n     <= w_blank ? 8'hFF : ~{1'b0, seg_pattern(w_digit)};
            r_last_digit     <= w_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_digit_enable_n = r_digit_enable_n;
    assign o_segments_n     = r_segments_n;
    assign o_last_digit     = r_last_digit;

endmodule

// ===== design/seven_segment_decimal_scan.sv =====
// ----------------------------------------------------------------------------
// Seven-segment decimal scan
// Turns a 16-bit value into a stream of multiplexed seven-segment digits.
// ----------------------------------------------------------------------------
// Each request carries a value and a command: left four digits (positions 1
// to 4), right four digits (positions 5 to 8) or all eight digits. Four-digit
// commands saturate the value to 9999; the unused command yields no result.
// The block emits one result per scanned position, in position order, with an
// active-low digit enable, active-low segments (blank is 0xFF, leading zeros
// blanked, final digit always shown) and a last flag. The converter makes one
// divide-by-ten step per cycle through a 16x16 reciprocal multiplier and holds
// its finished digits while the queue is full; the scanner drives one digit per
// cycle while the output is not stalled. The converter limits the request rate
// for four-digit commands and the scanner limits it for all eight digits. A
// two-entry queue lets the converter take new requests while digits drain.
module seven_segment_decimal_scan import ssds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_value,
    input  logic [1:0]  i_command,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_digit_enable_n,
    output logic [7:0]  o_segments_n,
    output logic        o_last_digit
);

    logic         w_push_valid;
    logic         w_push_ready;
    t_queue_entry w_push_entry;
    logic         w_pop_valid;
    logic         w_pop_ready;
    t_queue_entry w_pop_entry;

    ssds_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_value      (i_value),
        .i_command    (i_command),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_entry (w_push_entry)
    );

    ssds_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_entry (w_push_entry),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_entry  (w_pop_entry)
    );

    ssds_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pop_valid      (w_pop_valid),
        .o_pop_ready      (w_pop_ready),
        .i_pop_entry      (w_pop_entry),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digit_enable_n (o_digit_enable_n),
        .o_segments_n     (o_segments_n),
        .o_last_digit     (o_last_digit)
    );

endmodule

// ===== design/ssds_checker.sv =====
// ----------------------------------------------------------------------------
// Seven-segment decimal scan: port checker
// Concurrent checks on the request and output streams, bound to the top level.
// ----------------------------------------------------------------------------
`include "seven_segment_decimal_scan_macros.svh"

module ssds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [15:0] i_value,
    input logic [1:0]  i_command,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_digit_enable_n,
    input logic [7:0]  o_segments_n,
    input logic        o_last_digit
);

    logic        w_in_wait;
    logic [17:0] w_in_req;
    logic        w_out_wait;
    logic [16:0] w_out_res;
    logic        w_out_last;
    logic        w_last_ok;

    assign w_in_wait  = i_in_valid && !o_in_ready;
    assign w_in_req   = {i_value, i_command};
    assign w_out_wait = o_out_valid && !i_out_ready;
    assign w_out_res  = {o_digit_enable_n, o_segments_n, o_last_digit};
    assign w_out_last = o_out_valid && o_last_digit;
    // final digit sits at position 4 or position 8
    assign w_last_ok  = (o_segments_n != 8'hFF)
                        && (!o_digit_enable_n[0] || !o_digit_enable_n[4]);

    `SSDS_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_out_valid, "result valid after reset")

    `SSDS_ASSERT(a_in_hold, w_in_wait |=> i_in_valid && $stable(w_in_req), "request dropped")

    `SSDS_ASSERT(a_out_hold, w_out_wait |=> o_out_valid && $stable(w_out_res), "stalled result changed")

    `SSDS_ASSERT(a_one_digit, o_out_valid |-> $countones(~o_digit_enable_n) == 1, "not one-hot")

    `SSDS_ASSERT(a_last_shown, w_out_last |-> w_last_ok, "final digit blanked or misplaced")

endmodule

bind seven_segment_decimal_scan ssds_checker u_ssds_checker (.*);

// ===== bench/seven_segment_decimal_scan_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Seven-segment decimal scan testbench
// Runs a table of edge-case requests, then random requests with idle bursts
// on both sides, and checks every digit result against a scan predictor or hand-typed expectations.
// ----------------------------------------------------------------------------
module seven_segment_decimal_scan_tb;
    import ssds_pkg::*;

    // Segment codes for digits 9 down to 0, active high
    localparam logic [9:0][7:0] DIGIT_GLYPH = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };
    localparam int RANDOM_REQUESTS = 246;
    localparam int QUIET_FROM      = 206;
    localparam int LONG_HOLD       = 160;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct packed {
        logic [7:0] enable_n;
        logic [7:0] segments_n;
        logic       last_digit;
    } t_digit_result;

    typedef struct packed {
        logic [15:0] value;
        logic [1:0]  command;
        logic        typed;
        logic [3:0]  count;
        logic [63:0] enable_n;     // first result in the top byte
        logic [63:0] segments_n;
    } t_scan_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_value;
    logic [1:0]  i_command;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_digit_enable_n;
    logic [7:0]  o_segments_n;
    logic        o_last_digit;

    t_digit_result pending_digits[$];
    t_scan_row     scan_table[$];
    int            fail_count;
    int            digits_seen;
    bit            quiet_phase;
    bit            long_hold_done;

    seven_segment_decimal_scan u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_value          (i_value),
        .i_command        (i_command),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digit_enable_n (o_digit_enable_n),
        .o_segments_n     (o_segments_n),
        .o_last_digit     (o_last_digit)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void predict_scan(input logic [15:0] value, input logic [1:0] command);
        logic [3:0]    digit [8];
        int            n_pos;
        int            first_pos;
        int            v;
        bit            leading;
        bit            last;
        logic [7:0]    glyph;
        t_digit_result r;
        v = value;
        leading = 1'b1;
        case (command)
            CMD_LEFT, CMD_RIGHT: begin
                if (v > FOUR_DIGIT_MAX)
                    v = FOUR_DIGIT_MAX;
                digit[0] = 4'(v / 1000);
                digit[1] = 4'((v % 1000) / 100);
                digit[2] = 4'((v % 100) / 10);
                digit[3] = 4'(v % 10);
                n_pos = 4;
                first_pos = (command == CMD_LEFT) ? 1 : 5;
            end
            CMD_ALL: begin
                for (int i = 7; i >= 0; i--) begin
                    digit[i] = 4'(v % 10);
                    v = v / 10;
                end
                n_pos = 8;
                first_pos = 1;
            end
            default: n_pos = 0;
        endcase
        for (int i = 0; i < n_pos; i++) begin
            last = (i == n_pos - 1);
            if (leading && digit[i] == 4'd0 && !last) begin
                glyph = 8'h00;
            end else begin
                leading = 1'b0;
                glyph = DIGIT_GLYPH[digit[i]];
            end
            r.enable_n   = ~(8'h01 << (8 - (first_pos + i)));
            r.segments_n = ~glyph;
            r.last_digit = last;
            pending_digits.push_back(r);
        end
    endfunction

    task automatic add_row(input logic [15:0] value, input logic [1:0] command,
                           input logic typed, input logic [3:0] count,
                           input logic [63:0] enable_n, input logic [63:0] segments_n);
        t_scan_row row;
        row.value      = value;
        row.command    = command;
        row.typed      = typed;
        row.count      = count;
        row.enable_n   = enable_n;
        row.segments_n = segments_n;
        scan_table.push_back(row);
    endtask

    // Offer one request, hold it until accepted, then maybe idle a burst
    task automatic send_scan(input t_scan_row row, input bit may_idle);
        t_digit_result r;
        i_in_valid <= 1'b1;
        i_value    <= row.value;
        i_command  <= row.command;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (row.typed) begin
            for (int k = 0; k < row.count; k++) begin
                r.enable_n   = row.enable_n[63 - 8 * k -: 8];
                r.segments_n = row.segments_n[63 - 8 * k -: 8];
                r.last_digit = (k == row.count - 1);
                pending_digits.push_back(r);
            end
        end else begin
            predict_scan(row.value, row.command);
        end
        if (may_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Always advance the clock first so a dropped valid settles before the next request
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pending_digits.size() != 0);
    endtask

    // Receiver: random stalls, plus one long hold to back up the block
    initial begin
        forever begin
            @(posedge i_clk);
            if (!long_hold_done && digits_seen >= 300) begin
                long_hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet_phase && $urandom_range(0, 9) < 3) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_digit_result exp_digit;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            digits_seen++;
            if (pending_digits.size() == 0) begin
                $error("unexpected digit result: enable_n %h segments_n %h last %b",
                       o_digit_enable_n, o_segments_n, o_last_digit);
                fail_count++;
            end else begin
                exp_digit = pending_digits.pop_front();
                if (o_digit_enable_n !== exp_digit.enable_n) begin
                    $error("digit_enable_n: expected %h, got %h",
                           exp_digit.enable_n, o_digit_enable_n);
                    fail_count++;
                end
                if (o_segments_n !== exp_digit.segments_n) begin
                    $error("segments_n: expected %h, got %h",
                           exp_digit.segments_n, o_segments_n);
                    fail_count++;
                end
                if (o_last_digit !== exp_digit.last_digit) begin
                    $error("last_digit: expected %b, got %b",
                           exp_digit.last_digit, o_last_digit);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_scan_row row;
        int        pick;
        int        decade;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_value        = 16'd0;
        i_command      = CMD_LEFT;
        i_out_ready    = 1'b0;
        fail_count     = 0;
        digits_seen    = 0;
        quiet_phase    = 1'b0;
        long_hold_done = 1'b0;

        // Zero, the largest value and the unused command, typed in by hand
        add_row(16'd0, CMD_LEFT, 1'b1, 4'd4,
                {8'h7F, 8'hBF, 8'hDF, 8'hEF, 32'h0}, {8'hFF, 8'hFF, 8'hFF, 8'hC0, 32'h0});
        add_row(16'd65535, CMD_LEFT, 1'b1, 4'd4,
                {8'h7F, 8'hBF, 8'hDF, 8'hEF, 32'h0}, {8'h90, 8'h90, 8'h90, 8'h90, 32'h0});
        add_row(16'd65535, CMD_RIGHT, 1'b1, 4'd4,
                {8'hF7, 8'hFB, 8'hFD, 8'hFE, 32'h0}, {8'h90, 8'h90, 8'h90, 8'h90, 32'h0});
        add_row(16'd0, CMD_ALL, 1'b1, 4'd8,
                64'h7FBF_DFEF_F7FB_FDFE, 64'hFFFF_FFFF_FFFF_FFC0);
        add_row(16'd65535, CMD_ALL, 1'b1, 4'd8,
                64'h7FBF_DFEF_F7FB_FDFE, 64'hFFFF_FF82_9292_B092);
        add_row(16'd0, CMD_NONE, 1'b1, 4'd0, 64'h0, 64'h0);
        add_row(16'd65535, CMD_NONE, 1'b1, 4'd0, 64'h0, 64'h0);
        // Saturation edge, single digits, inner zeros and bit patterns
        add_row(16'd9999,   CMD_LEFT,  1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd10000,  CMD_LEFT,  1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd10000,  CMD_RIGHT, 1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd0,      CMD_RIGHT, 1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd1,      CMD_LEFT,  1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd1,      CMD_RIGHT, 1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd1,      CMD_ALL,   1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd1000,   CMD_RIGHT, 1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd1234,   CMD_LEFT,  1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd5678,   CMD_RIGHT, 1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd90,     CMD_ALL,   1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd50005,  CMD_ALL,   1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd12345,  CMD_ALL,   1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'h5555,   CMD_ALL,   1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'hAAAA,   CMD_ALL,   1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd7,      CMD_ALL,   1'b0, 4'd0, 64'h0, 64'h0);
        add_row(16'd9,      CMD_LEFT,  1'b0, 4'd0, 64'h0, 64'h0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (scan_table[n])
            send_scan(scan_table[n], 1'b1);

        // Hold off new requests until every digit has drained
        i_in_valid <= 1'b0;
        wait_drained();

        row.typed      = 1'b0;
        row.count      = 4'd0;
        row.enable_n   = 64'h0;
        row.segments_n = 64'h0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 2) begin
                i_in_valid <= 1'b0;
                wait_drained();
            end
            if (n == QUIET_FROM)
                quiet_phase = 1'b1;
            pick = $urandom_range(0, 5);
            case (pick)
                0: row.value = 16'($urandom_range(0, 99));
                1: row.value = 16'($urandom_range(9990, 10010));
                2: begin
                    decade = $urandom_range(0, 4);
                    row.value = 16'((10 ** decade) + $urandom_range(0, 2) - 1);
                end
                default: row.value = 16'($urandom);
            endcase
            pick = $urandom_range(0, 11);
            case (pick)
                0:          row.command = CMD_NONE;
                1, 2, 3, 4: row.command = CMD_LEFT;
                5, 6, 7:    row.command = CMD_RIGHT;
                default:    row.command = CMD_ALL;
            endcase
            send_scan(row, !quiet_phase);
        end
        i_in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_digits.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/ssds_pkg.sv
design/ssds_front.sv
design/ssds_queue.sv
design/ssds_back.sv
design/seven_segment_decimal_scan.sv
design/ssds_checker.sv
bench/seven_segment_decimal_scan_tb.sv
